[rtl/urh_pkg.sv]
// Package for the undo/redo history stack: command codes, field widths,
// parameter defaults and the controller/datapath handshake structs.
// No dependencies.
package urh_pkg;

  localparam int CMD_W          = 3;
  localparam int KIND_W         = 4;
  localparam int KEY_W          = 16;
  localparam int CFG_W          = 5;
  localparam int CNT_OUT_W      = 5;
  localparam int RESTORE_W      = 32;
  localparam int OUT_DATA_W     = 48;
  localparam int OUT_PAD_W      = OUT_DATA_W - RESTORE_W - 2 * CNT_OUT_W;
  localparam int DEPTH_DEF      = 16;
  localparam int SNAP_WIDTH_DEF = 32;

  localparam logic [CFG_W-1:0] MAX_STEPS_RST = 5'd16;

  localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RUN_PUSH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_END_RUN  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNDO     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REDO     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctl_sts_t;

endpackage

[rtl/undo_redo_history_stack_core.sv]
// Top level of the undo/redo history stack: joins the controller and the
// datapath. Depends on urh_pkg, urh_ctrl and urh_dpath.
//
// Channel  Direction  Payload
// in_      slave      tuser: command; tdata: step_kind, run_key, before_snap, after_snap
// out_     master     tuser: accepted; tdata: restored_snap, undo_count, redo_count
// cfg_     slave      data: max_steps
//
// Each request goes through capture, registered snapshot ring read, then commit.
// Commit waits while the result register is full and not being taken.
// Synchronous reset empties the history and sets max_steps to 16; no clearing pass.
// The configuration channel is always ready and takes one write per cycle.
module undo_redo_history_stack_core import urh_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int SNAP_WIDTH = SNAP_WIDTH_DEF,
  parameter int IN_DATA_W  = ((KIND_W + KEY_W + 2 * SNAP_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // step_kind, run_key, before_snap, after_snap, zero padding
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // restored_snap, undo_count, redo_count, zero padding
  output logic [OUT_DATA_W-1:0] out_tdata,
  // accepted
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  assign cfg_ready = 1'b1;

  urh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (ctl_sts),
    .cmd       (ctl_cmd)
  );

  urh_dpath #(
    .DEPTH      (DEPTH),
    .SNAP_WIDTH (SNAP_WIDTH),
    .IN_DATA_W  (IN_DATA_W)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctl_cmd),
    .sts        (ctl_sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/urh_ctrl.sv]
// Controller of the undo/redo history stack: sequences capture, snapshot
// read and commit of one request at a time. Depends on urh_pkg.
module urh_ctrl import urh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/urh_dpath.sv]
// Datapath of the undo/redo history stack: snapshot ring memories, pointers,
// run tracking, the max_steps register and the result register.
// Depends on urh_pkg; driven by urh_ctrl.
module urh_dpath import urh_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int SNAP_WIDTH = SNAP_WIDTH_DEF,
  parameter int IN_DATA_W  = ((KIND_W + KEY_W + 2 * SNAP_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output ctl_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,
  input  logic                  cfg_valid,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int IW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SMW = CW + 1;
  localparam int LW  = (CW > CFG_W) ? CW : CFG_W;

  logic [SNAP_WIDTH-1:0] bmem [DEPTH];
  logic [SNAP_WIDTH-1:0] amem [DEPTH];

  logic [CMD_W-1:0]        cmd_r;
  logic [KIND_W-1:0]       kind_r;
  logic signed [KEY_W-1:0] key_r;
  logic [SNAP_WIDTH-1:0]   bsnap_r;
  logic [SNAP_WIDTH-1:0]   asnap_r;
  logic [SNAP_WIDTH-1:0]   bq_r;
  logic [SNAP_WIDTH-1:0]   aq_r;

  logic [IW-1:0]           oldest_r, oldest_nxt;
  logic [CW-1:0]           stored_r, stored_nxt;
  logic [CW-1:0]           applied_r, applied_nxt;
  logic                    run_open_r, run_open_nxt;
  logic [KIND_W-1:0]       run_kind_r, run_kind_nxt;
  logic signed [KEY_W-1:0] run_key_r, run_key_nxt;
  logic [CFG_W-1:0]        max_steps_r;

  logic                    out_valid_r;
  logic                    out_acc_r;
  logic [RESTORE_W-1:0]    out_snap_r;
  logic [CNT_OUT_W-1:0]    out_undo_r;
  logic [CNT_OUT_W-1:0]    out_redo_r;

  logic [CW-1:0]           rd_idx;
  logic [IW-1:0]           rd_slot;
  logic [LW-1:0]           m_ext;
  logic [CW-1:0]           lim;
  logic                    push_ok;
  logic [IW-1:0]           p_old1, p_old2, p_slot;
  logic [CW-1:0]           p_st1, p_st2, p_st3;
  logic                    run_match;
  logic                    we_b, we_a;
  logic [IW-1:0]           w_slot;
  logic                    acc;
  logic [SNAP_WIDTH-1:0]   snap;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SMW-1:0] s;
    s = SMW'(base) + SMW'(off);
    if (s >= SMW'(DEPTH)) begin
      s = s - SMW'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  assign rd_idx  = (cmd_r == CMD_REDO) ? applied_r : applied_r - CW'(1);
  assign rd_slot = slot_of(oldest_r, rd_idx);

  assign m_ext = LW'(max_steps_r);
  assign lim   = (m_ext == '0 || m_ext > LW'(DEPTH)) ? CW'(DEPTH) : CW'(m_ext);

  assign push_ok = (bsnap_r != asnap_r);

  always_comb begin
    if (applied_r >= CW'(DEPTH)) begin
      p_old1 = slot_of(oldest_r, CW'(1));
      p_st1  = applied_r - CW'(1);
    end else begin
      p_old1 = oldest_r;
      p_st1  = applied_r;
    end
    p_slot = slot_of(p_old1, p_st1);
    p_st2  = p_st1 + CW'(1);
    if (p_st2 > lim) begin
      p_old2 = slot_of(p_old1, p_st2 - lim);
      p_st3  = lim;
    end else begin
      p_old2 = p_old1;
      p_st3  = p_st2;
    end
  end

  assign run_match = run_open_r && (run_kind_r == kind_r) && (run_key_r == key_r) &&
                     (applied_r != '0) && (applied_r == stored_r);

  always_comb begin
    oldest_nxt   = oldest_r;
    stored_nxt   = stored_r;
    applied_nxt  = applied_r;
    run_open_nxt = run_open_r;
    run_kind_nxt = run_kind_r;
    run_key_nxt  = run_key_r;
    we_b         = 1'b0;
    we_a         = 1'b0;
    w_slot       = p_slot;
    acc          = 1'b0;
    snap         = '0;
    case (cmd_r)
      CMD_PUSH: begin
        if (push_ok) begin
          we_b         = 1'b1;
          we_a         = 1'b1;
          oldest_nxt   = p_old2;
          stored_nxt   = p_st3;
          applied_nxt  = p_st3;
          run_open_nxt = 1'b0;
          acc          = 1'b1;
        end
      end
      CMD_RUN_PUSH: begin
        if (run_match) begin
          if (bq_r == asnap_r) begin
            stored_nxt   = applied_r - CW'(1);
            applied_nxt  = applied_r - CW'(1);
            run_open_nxt = 1'b0;
          end else begin
            we_a   = 1'b1;
            w_slot = rd_slot;
            acc    = 1'b1;
          end
        end else if (push_ok) begin
          we_b         = 1'b1;
          we_a         = 1'b1;
          oldest_nxt   = p_old2;
          stored_nxt   = p_st3;
          applied_nxt  = p_st3;
          run_open_nxt = 1'b1;
          run_kind_nxt = kind_r;
          run_key_nxt  = key_r;
          acc          = 1'b1;
        end
      end
      CMD_END_RUN: begin
        run_open_nxt = 1'b0;
      end
      CMD_UNDO: begin
        if (applied_r != '0) begin
          run_open_nxt = 1'b0;
          applied_nxt  = applied_r - CW'(1);
          snap         = bq_r;
          acc          = 1'b1;
        end
      end
      CMD_REDO: begin
        if (applied_r < stored_r) begin
          run_open_nxt = 1'b0;
          applied_nxt  = applied_r + CW'(1);
          snap         = aq_r;
          acc          = 1'b1;
        end
      end
      CMD_CLEAR: begin
        stored_nxt   = '0;
        applied_nxt  = '0;
        run_open_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_tuser;
      kind_r  <= in_tdata[KIND_W-1:0];
      key_r   <= $signed(in_tdata[KIND_W +: KEY_W]);
      bsnap_r <= in_tdata[KIND_W + KEY_W +: SNAP_WIDTH];
      asnap_r <= in_tdata[KIND_W + KEY_W + SNAP_WIDTH +: SNAP_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      bq_r <= bmem[rd_slot];
    end
    if (cmd.commit && we_b) begin
      bmem[w_slot] <= bsnap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      aq_r <= amem[rd_slot];
    end
    if (cmd.commit && we_a) begin
      amem[w_slot] <= asnap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      stored_r    <= '0;
      applied_r   <= '0;
      run_open_r  <= 1'b0;
      run_kind_r  <= '0;
      run_key_r   <= '0;
      max_steps_r <= MAX_STEPS_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_steps_r <= cfg_data;
      end
      if (cmd.commit) begin
        oldest_r    <= oldest_nxt;
        stored_r    <= stored_nxt;
        applied_r   <= applied_nxt;
        run_open_r  <= run_open_nxt;
        run_kind_r  <= run_kind_nxt;
        run_key_r   <= run_key_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_acc_r  <= acc;
      out_snap_r <= RESTORE_W'(snap);
      out_undo_r <= CNT_OUT_W'(applied_nxt);
      out_redo_r <= CNT_OUT_W'(stored_nxt - applied_nxt);
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tuser    = out_acc_r;
  assign out_tdata    = {{OUT_PAD_W{1'b0}}, out_redo_r, out_undo_r, out_snap_r};

  a_applied_le_stored: assert property (@(posedge clk) disable iff (!rst_n)
    applied_r <= stored_r)
    else $error("applied step count exceeds stored step count");

  a_stored_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= CW'(DEPTH))
    else $error("stored step count exceeds ring depth");

  a_oldest_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    oldest_r < IW'(DEPTH - 1) || oldest_r == IW'(DEPTH - 1))
    else $error("oldest slot outside the ring");

  a_commit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed request produced no result");

endmodule
